// File: hw/rtl/merge_sort_engine_unit_assert.svh
// assertion shorthands shared by the sort engine modules
// each expects clk and arst_n in scope
`ifndef MERGE_SORT_ENGINE_UNIT_ASSERT_SVH
`define MERGE_SORT_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication
`define MSE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MSE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/mse_pkg.sv
package mse_pkg;

	// capacity of the element store
	localparam int MAX_ELEMENTS = 16;
	localparam int ADDR_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
	// run bounds before clamping reach below three times the capacity
	localparam int RUN_W = ADDR_W + 3;
	localparam int DATA_W = 32;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic sort_init;
		logic merge_wr;
		logic emit;
		logic clear;
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic n_le1;
		logic sort_done;
		logic emit_end;
	} status_t;

endpackage

// File: hw/rtl/mse_datapath.sv
`include "merge_sort_engine_unit_assert.svh"

module mse_datapath import mse_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	input  logic signed [DATA_W-1:0] value,
	output status_t                  status,
	output logic                     strobe,
	output logic signed [DATA_W-1:0] sorted_value,
	output logic                     last_out,
	output logic                     dropped
);

	localparam int MEM_DEPTH = 2 ** (ADDR_W + 1);

	// two banks of element storage, bank 0 is filled on load
	logic [DATA_W-1:0] mem_q [MEM_DEPTH];

	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic             bank_q;
	logic [RUN_W-1:0] width_q;
	logic [CNT_W-1:0] i_q, j_q, k_q, mid_q, hi_q, e_q;
	logic signed [DATA_W-1:0] rd_a_q, rd_b_q;
	logic             strobe_s1, last_s1, drop_s1;

	logic [RUN_W-1:0]  n_run, width2, lo_sel, w_sel, mid_sum, hi_sum;
	logic [CNT_W-1:0]  mid_c, hi_c, idx_a;
	logic              take_a, run_end, pass_end, sort_done;
	logic              wr_en;
	logic [ADDR_W:0]   wr_addr;
	logic [DATA_W-1:0] wr_data;
	logic              in_run;

	// merge decision and run bookkeeping
	always_comb begin
		n_run    = RUN_W'(count_q);
		width2   = width_q << 1;
		take_a   = (i_q < mid_q) && ((j_q >= hi_q) || (rd_a_q < rd_b_q));
		run_end  = (k_q + CNT_W'(1)) == hi_q;
		pass_end = run_end && (hi_q == count_q);
		sort_done = pass_end && (width2 >= n_run);
	end

	// bounds of the next run, clamped to the element count
	always_comb begin
		if (cmd.sort_init) begin
			lo_sel = '0;
			w_sel  = RUN_W'(1);
		end else if (pass_end) begin
			lo_sel = '0;
			w_sel  = width2;
		end else begin
			lo_sel = RUN_W'(hi_q);
			w_sel  = width_q;
		end
		mid_sum = lo_sel + w_sel;
		hi_sum  = lo_sel + (w_sel << 1);
		mid_c   = (mid_sum > n_run) ? count_q : mid_sum[CNT_W-1:0];
		hi_c    = (hi_sum > n_run) ? count_q : hi_sum[CNT_W-1:0];
	end

	// write port: load into bank 0 or merge into the other bank
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = {1'b0, k_q[ADDR_W-1:0]};
		wr_data = take_a ? rd_a_q : rd_b_q;
		if (cmd.load) begin
			wr_en   = (count_q < CNT_W'(MAX_ELEMENTS));
			wr_addr = {1'b0, count_q[ADDR_W-1:0]};
			wr_data = value;
		end else if (cmd.merge_wr) begin
			wr_en   = 1'b1;
			wr_addr = {~bank_q, k_q[ADDR_W-1:0]};
		end
	end

	assign idx_a = cmd.emit ? e_q : i_q;

	// element memory, two registered read ports
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_a_q <= mem_q[{bank_q, idx_a[ADDR_W-1:0]}];
		rd_b_q <= mem_q[{bank_q, j_q[ADDR_W-1:0]}];
	end

	// element count and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.clear) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.load) begin
			if (count_q < CNT_W'(MAX_ELEMENTS)) begin
				count_q <= count_q + CNT_W'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	// pass and run indices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= 1'b0;
		end else if (cmd.sort_init) begin
			bank_q <= 1'b0;
		end else if (cmd.merge_wr && pass_end) begin
			bank_q <= ~bank_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sort_init || (cmd.merge_wr && run_end)) begin
			width_q <= w_sel;
			i_q     <= lo_sel[CNT_W-1:0];
			k_q     <= lo_sel[CNT_W-1:0];
			j_q     <= mid_c;
			mid_q   <= mid_c;
			hi_q    <= hi_c;
		end else if (cmd.merge_wr) begin
			k_q <= k_q + CNT_W'(1);
			if (take_a) begin
				i_q <= i_q + CNT_W'(1);
			end else begin
				j_q <= j_q + CNT_W'(1);
			end
		end
	end

	// emission counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_q <= '0;
		end else begin
			e_q <= cmd.emit ? e_q + CNT_W'(1) : '0;
		end
	end

	// result stage, aligned with the registered read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_s1 <= 1'b0;
		end else begin
			strobe_s1 <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= status.emit_end;
		drop_s1 <= ovf_q;
	end

	assign status.n_le1     = (count_q <= CNT_W'(1));
	assign status.sort_done = sort_done;
	assign status.emit_end  = (e_q + CNT_W'(1)) == count_q;

	assign strobe       = strobe_s1;
	assign sorted_value = rd_a_q;
	assign last_out     = last_s1;
	assign dropped      = drop_s1;

	// checks
	assign in_run = (k_q < hi_q) && ((i_q < mid_q) || (j_q < hi_q));

	`MSE_ASSERT_NXT(a_last_ends_set, strobe && last_out, !strobe, "item after last of set")
	`MSE_ASSERT_IMP(a_merge_in_run, cmd.merge_wr, in_run, "merge index outside run")
	`MSE_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(MAX_ELEMENTS), "count above capacity")

endmodule

// File: hw/rtl/mse_ctrl.sv
`include "merge_sort_engine_unit_assert.svh"

module mse_ctrl import mse_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    is_last,
	input  status_t status,
	output cmd_t    cmd,
	output logic    busy
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_INIT = 5'b00010,
		ST_RD   = 5'b00100,
		ST_WR   = 5'b01000,
		ST_EMIT = 5'b10000
	} state_t;

	state_t state_q, state_d;

	// sequencing of load, merge passes and emission
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (is_last) begin
						state_d = ST_INIT;
					end
				end
			end
			ST_INIT: begin
				cmd.sort_init = 1'b1;
				state_d = status.n_le1 ? ST_EMIT : ST_RD;
			end
			ST_RD: begin
				state_d = ST_WR;
			end
			ST_WR: begin
				cmd.merge_wr = 1'b1;
				state_d = status.sort_done ? ST_EMIT : ST_RD;
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				if (status.emit_end) begin
					cmd.clear = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

	// checks
	`MSE_ASSERT_NXT(a_busy_on_last_only, !busy && !(start && is_last), !busy, "busy without end of set")
	`MSE_ASSERT_IMP(a_merge_needs_two, cmd.merge_wr, !status.n_le1, "merge with fewer than two items")
	`MSE_ASSERT_IMP(a_state_onehot, 1'b1, $onehot(state_q), "state code not one-hot")

endmodule

// File: hw/rtl/merge_sort_engine_unit.sv
// Sorting engine for sets of up to sixteen signed 32-bit items. Items are
// accepted one per cycle while busy is low; the item flagged is_last closes
// the set, busy rises and the stored items are merge sorted in bottom-up
// passes between two banks of one element memory. Each merge step is a
// read state (registered read of both run heads), then a write state
// (compare and write); a set-up state precedes the first pass. The N
// results then come out on consecutive cycles, each marked by
// strobe for exactly one cycle, in ascending order, last_out on the final
// one. The receiver cannot stall the results. Items beyond capacity are
// discarded and every result of that set carries dropped. busy falls in the
// cycle of the final result.
module merge_sort_engine_unit import mse_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [DATA_W-1:0] value,
	input  logic                     is_last,
	output logic                     strobe,
	output logic signed [DATA_W-1:0] sorted_value,
	output logic                     last_out,
	output logic                     dropped
);

	cmd_t    cmd;
	status_t status;

	// sequencer
	mse_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.is_last (is_last),
		.status  (status),
		.cmd     (cmd),
		.busy    (busy)
	);

	// storage, merge logic and result stage
	mse_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.value        (value),
		.status       (status),
		.strobe       (strobe),
		.sorted_value (sorted_value),
		.last_out     (last_out),
		.dropped      (dropped)
	);

endmodule

// File: verif/merge_sort_engine_unit_test.sv
module merge_sort_engine_unit_test;
	import mse_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 260;
	localparam int DRAIN_TAIL = 40;
	localparam int MAX_REPORTS = 40;

	// how the values of one random set are drawn
	typedef enum int {MIX_WIDE, MIX_NARROW, MIX_EDGE} value_mix_t;

	typedef struct {
		logic signed [DATA_W-1:0] element;
		logic                     final_one;
		logic                     lost;
	} sorted_entry_t;

	// mirrors the element store and predicts the sorted output of each set
	class ascending_set_tracker;
		logic signed [DATA_W-1:0] bank [2][MAX_ELEMENTS];
		int held_count;
		bit overflow;
		sorted_entry_t sorted_due[$];
		int mismatches;

		function void flag(string field, logic signed [DATA_W-1:0] expected,
				logic signed [DATA_W-1:0] actual);
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, actual %0d",
					$time, field, expected, actual);
		endfunction

		// bottom-up merge passes, ping-ponging between the two banks
		function void merge_sort_held();
			int src, width, lo, mid, hi, i, j, k;
			bit take_left;
			src = 0;
			for (width = 1; width < held_count; width *= 2) begin
				for (lo = 0; lo < held_count; lo += 2 * width) begin
					mid = (lo + width > held_count) ? held_count : lo + width;
					hi = (lo + 2 * width > held_count) ? held_count : lo + 2 * width;
					i = lo;
					j = mid;
					for (k = lo; k < hi; k++) begin
						take_left = (i < mid) && (j >= hi || bank[src][i] < bank[src][j]);
						if (take_left) begin
							bank[1 - src][k] = bank[src][i];
							i++;
						end else begin
							bank[1 - src][k] = bank[src][j];
							j++;
						end
					end
				end
				src = 1 - src;
			end
			if (src != 0)
				for (k = 0; k < held_count; k++)
					bank[0][k] = bank[1][k];
		endfunction

		// one accepted item: store it, and on the closing item queue the sorted set
		function void take_element(logic signed [DATA_W-1:0] element, bit closes_set);
			sorted_entry_t entry;
			if (held_count < MAX_ELEMENTS) begin
				bank[0][held_count] = element;
				held_count++;
			end else begin
				overflow = 1'b1;
			end
			if (closes_set) begin
				merge_sort_held();
				for (int k = 0; k < held_count; k++) begin
					entry.element = bank[0][k];
					entry.final_one = (k == held_count - 1);
					entry.lost = overflow;
					sorted_due.push_back(entry);
				end
				held_count = 0;
				overflow = 1'b0;
			end
		endfunction

		// one strobed result against the oldest expected element
		function void compare_sorted(logic signed [DATA_W-1:0] element, logic final_one,
				logic lost);
			sorted_entry_t entry;
			if (sorted_due.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected result, expected none, actual %0d",
						$time, element);
				return;
			end
			entry = sorted_due.pop_front();
			if (element !== entry.element)
				flag("sorted_value", entry.element, element);
			if (final_one !== entry.final_one)
				flag("last_out", entry.final_one, final_one);
			if (lost !== entry.lost)
				flag("dropped", entry.lost, lost);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [DATA_W-1:0] value;
	logic is_last;
	logic strobe;
	logic signed [DATA_W-1:0] sorted_value;
	logic last_out;
	logic dropped;

	ascending_set_tracker tracker = new;
	int quiet_cycles = 0;
	int items_sent = 0;

	merge_sort_engine_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.value        (value),
		.is_last      (is_last),
		.strobe       (strobe),
		.sorted_value (sorted_value),
		.last_out     (last_out),
		.dropped      (dropped)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watch both sides of the block at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe)
				tracker.compare_sorted(sorted_value, last_out, dropped);
			if (start && !busy)
				tracker.take_element(value, is_last);
			if (strobe || (start && !busy))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("Verification failed");
				$finish;
			end
		end
	end

	// present one item from a falling edge and hold it until taken
	task send_item(input logic signed [DATA_W-1:0] element, input bit closes_set,
			input int idle_pct);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		start = 1'b1;
		value = element;
		is_last = closes_set;
		do
			@(posedge clk);
		while (busy);
		items_sent++;
		@(negedge clk);
	endtask

	// hold off the sender until every queued result has come out
	task wait_drained();
		start = 1'b0;
		while (tracker.sorted_due.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_element(value_mix_t mix);
		int narrow;
		case (mix)
			MIX_NARROW: begin
				narrow = $urandom_range(8);
				return narrow - 4;
			end
			MIX_EDGE: begin
				case ($urandom_range(3))
					0: return 32'sh7fff_ffff;
					1: return 32'sh8000_0000;
					2: return -1;
					default: return 0;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int sender_idle [4];
		int phase, next_phase, set_size, random_base;
		value_mix_t mix;

		sender_idle = '{0, 45, 0, 6};
		arst_n = 1'b0;
		start = 1'b0;
		value = '0;
		is_last = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// single-element set at the top of the range
		send_item(32'sh7fff_ffff, 1'b1, 0);
		// both extremes, minus one and zero
		send_item(32'sh7fff_ffff, 1'b0, 0);
		send_item(-1, 1'b0, 0);
		send_item(0, 1'b0, 0);
		send_item(32'sh8000_0000, 1'b1, 0);
		// equal values
		send_item(-3, 1'b0, 0);
		send_item(-3, 1'b1, 0);
		// full store, then a discarded item that closes the set
		for (int k = 0; k < MAX_ELEMENTS; k++)
			send_item(1000 - k * 37, 1'b0, 0);
		send_item(32'sh1234_5678, 1'b1, 0);
		wait_drained();

		// random sets across the idling phases
		random_base = items_sent;
		phase = 0;
		while (items_sent - random_base < RANDOM_ITEMS) begin
			next_phase = (items_sent - random_base) * 4 / RANDOM_ITEMS;
			if (next_phase > 3)
				next_phase = 3;
			if (next_phase != phase) begin
				wait_drained();
				phase = next_phase;
			end
			case ($urandom_range(7))
				0: set_size = $urandom_range(MAX_ELEMENTS + 1, MAX_ELEMENTS + 4);
				1: set_size = $urandom_range(1, 2);
				default: set_size = $urandom_range(1, MAX_ELEMENTS);
			endcase
			mix = value_mix_t'($urandom_range(2));
			for (int k = 0; k < set_size; k++)
				send_item(pick_element(mix), k == set_size - 1, sender_idle[phase]);
		end

		// let the last set come out, then allow for stray results
		wait_drained();
		repeat (DRAIN_TAIL) @(posedge clk);
		if (tracker.sorted_due.size() != 0) begin
			tracker.mismatches++;
			$display("%0t: %0d expected results never came", $time,
				tracker.sorted_due.size());
		end
		if (tracker.mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
